[hw/rtl/epic_pkg.sv]
package epic_pkg;

    // Pipeline depth and the stage that each step of the test occupies.
    localparam int NUM_STAGES = 8;
    localparam int ST_PROD    = 0;
    localparam int ST_LINE    = 1;
    localparam int ST_MUL     = 2;
    localparam int ST_RES     = 3;
    localparam int ST_NORM    = 4;
    localparam int ST_RSQ     = 5;
    localparam int ST_RHS     = 6;
    localparam int ST_CMP     = 7;

    // Configuration port.
    localparam int CFG_DATA_WIDTH  = 63;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int NUM_F_ROWS      = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_F_ROW0,
        CFG_F_ROW1,
        CFG_F_ROW2,
        CFG_DIST_THRESHOLD
    } cfg_index_t;

    // Threshold is unsigned Q8.8; its square carries sixteen fraction bits.
    localparam int                      THRESH_WIDTH = 16;
    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 16'd256;
    localparam int                      TSQ_WIDTH    = 2 * THRESH_WIDTH;
    localparam int                      TSQ_FRAC     = 16;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } stage_ctrl_t;

endpackage

[hw/rtl/epic_pair_if.sv]
interface epic_pair_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;

    modport source (
        output valid,
        output first_x,
        output first_y,
        output second_x,
        output second_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  first_x,
        input  first_y,
        input  second_x,
        input  second_y,
        output ready
    );
endinterface

[hw/rtl/epic_result_if.sv]
interface epic_result_if;
    logic valid;
    logic ready;
    logic is_inlier;

    modport source (
        output valid,
        output is_inlier,
        input  ready
    );

    modport sink (
        input  valid,
        input  is_inlier,
        output ready
    );
endinterface

[hw/rtl/epic_pipe_ctrl.sv]
module epic_pipe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output epic_pkg::stage_ctrl_t ctrl
);
    localparam int N = epic_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N-1:0] stage_ready;
    logic [N-1:0] upstream;

    // A stage may take new data when it is empty or its content moves on.
    always_comb
    begin
        stage_ready[N-1] = !valid_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_comb
    begin
        upstream = {valid_reg[N-2:0], in_valid};
        for (int k = 0; k < N; k++)
        begin
            valid_next[k]  = stage_ready[k] ? upstream[k] : valid_reg[k];
            ctrl.load[k]   = stage_ready[k] && upstream[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[N-1];
endmodule

[hw/rtl/epic_line_unit.sv]
module epic_line_unit #(
    parameter int COORD_WIDTH = 16,
    parameter int COORD_FRAC  = 4,
    parameter int COEF_WIDTH  = 21,
    parameter int LINE_WIDTH  = COORD_WIDTH + COEF_WIDTH + 1
) (
    input  logic                                   clk,
    input  epic_pkg::stage_ctrl_t                  ctrl,
    input  logic [epic_pkg::CFG_DATA_WIDTH-1:0]    f_row [epic_pkg::NUM_F_ROWS],
    input  logic signed [COORD_WIDTH-1:0]          first_x,
    input  logic signed [COORD_WIDTH-1:0]          first_y,
    input  logic signed [COORD_WIDTH-1:0]          second_x,
    input  logic signed [COORD_WIDTH-1:0]          second_y,
    output logic signed [LINE_WIDTH-1:0]           a0,
    output logic signed [LINE_WIDTH-1:0]           b0,
    output logic signed [LINE_WIDTH-1:0]           c0,
    output logic signed [LINE_WIDTH-1:0]           a1,
    output logic signed [LINE_WIDTH-1:0]           b1,
    output logic signed [COORD_WIDTH-1:0]          x0,
    output logic signed [COORD_WIDTH-1:0]          y0
);
    localparam int PW = COORD_WIDTH + COEF_WIDTH;
    localparam int R  = epic_pkg::NUM_F_ROWS;

    logic signed [COEF_WIDTH-1:0]  coef [R][R];
    logic signed [LINE_WIDTH-1:0]  kterm [R][R];

    logic signed [PW-1:0]          px1_reg [R];
    logic signed [PW-1:0]          py1_reg [R];
    logic signed [PW-1:0]          px0_reg [2];
    logic signed [PW-1:0]          py0_reg [2];
    logic signed [COORD_WIDTH-1:0] x0_s1_reg;
    logic signed [COORD_WIDTH-1:0] y0_s1_reg;

    logic signed [LINE_WIDTH-1:0]  a0_reg;
    logic signed [LINE_WIDTH-1:0]  b0_reg;
    logic signed [LINE_WIDTH-1:0]  c0_reg;
    logic signed [LINE_WIDTH-1:0]  a1_reg;
    logic signed [LINE_WIDTH-1:0]  b1_reg;
    logic signed [COORD_WIDTH-1:0] x0_reg;
    logic signed [COORD_WIDTH-1:0] y0_reg;

    // Constant terms of F are scaled to the coordinate fraction.
    always_comb
    begin
        for (int i = 0; i < R; i++)
        begin
            for (int j = 0; j < R; j++)
            begin
                coef[i][j]  = f_row[i][j*COEF_WIDTH +: COEF_WIDTH];
                kterm[i][j] = LINE_WIDTH'(coef[i][j]) <<< COORD_FRAC;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[epic_pkg::ST_PROD])
        begin
            for (int j = 0; j < R; j++)
            begin
                px1_reg[j] <= second_x * coef[0][j];
                py1_reg[j] <= second_y * coef[1][j];
            end
            for (int i = 0; i < 2; i++)
            begin
                px0_reg[i] <= first_x * coef[i][0];
                py0_reg[i] <= first_y * coef[i][1];
            end
            x0_s1_reg <= first_x;
            y0_s1_reg <= first_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[epic_pkg::ST_LINE])
        begin
            a0_reg <= LINE_WIDTH'(px1_reg[0]) + LINE_WIDTH'(py1_reg[0]) + kterm[2][0];
            b0_reg <= LINE_WIDTH'(px1_reg[1]) + LINE_WIDTH'(py1_reg[1]) + kterm[2][1];
            c0_reg <= LINE_WIDTH'(px1_reg[2]) + LINE_WIDTH'(py1_reg[2]) + kterm[2][2];
            a1_reg <= LINE_WIDTH'(px0_reg[0]) + LINE_WIDTH'(py0_reg[0]) + kterm[0][2];
            b1_reg <= LINE_WIDTH'(px0_reg[1]) + LINE_WIDTH'(py0_reg[1]) + kterm[1][2];
            x0_reg <= x0_s1_reg;
            y0_reg <= y0_s1_reg;
        end
    end

    assign a0 = a0_reg;
    assign b0 = b0_reg;
    assign c0 = c0_reg;
    assign a1 = a1_reg;
    assign b1 = b1_reg;
    assign x0 = x0_reg;
    assign y0 = y0_reg;
endmodule

[hw/rtl/epic_square.sv]
module epic_square #(
    parameter int WIDTH = 38
) (
    input  logic                   clk,
    input  logic                   en_part,
    input  logic                   en_sum,
    input  logic signed [WIDTH-1:0] value,
    output logic [2*WIDTH-1:0]     square
);
    // The value is split into a signed upper half and an unsigned lower
    // half, so each partial product stays near half the full width.
    localparam int LH = (WIDTH + 1) / 2;
    localparam int HW = WIDTH - LH;
    localparam int SW = 2 * WIDTH + 1;

    logic signed [HW-1:0]    hi;
    logic        [LH-1:0]    lo;
    logic signed [2*HW-1:0]  hh_reg;
    logic signed [HW+LH:0]   hl_reg;
    logic        [2*LH-1:0]  ll_reg;
    logic signed [SW-1:0]    sum;
    logic        [2*WIDTH-1:0] square_reg;

    assign hi = value[WIDTH-1:LH];
    assign lo = value[LH-1:0];

    always_ff @(posedge clk)
    begin
        if (en_part)
        begin
            hh_reg <= hi * hi;
            hl_reg <= hi * $signed({1'b0, lo});
            ll_reg <= lo * lo;
        end
    end

    always_comb
    begin
        sum = (SW'(hh_reg) <<< (2 * LH))
            + (SW'(hl_reg) <<< (LH + 1))
            + SW'($signed({1'b0, ll_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (en_sum)
        begin
            square_reg <= sum[2*WIDTH-1:0];
        end
    end

    assign square = square_reg;
endmodule

[hw/rtl/epic_resid_unit.sv]
module epic_resid_unit #(
    parameter int COORD_WIDTH = 16,
    parameter int COORD_FRAC  = 4,
    parameter int LINE_WIDTH  = 38,
    parameter int RES_WIDTH   = LINE_WIDTH + COORD_WIDTH + 2
) (
    input  logic                          clk,
    input  epic_pkg::stage_ctrl_t         ctrl,
    input  logic signed [LINE_WIDTH-1:0]  a0,
    input  logic signed [LINE_WIDTH-1:0]  b0,
    input  logic signed [LINE_WIDTH-1:0]  c0,
    input  logic signed [COORD_WIDTH-1:0] x0,
    input  logic signed [COORD_WIDTH-1:0] y0,
    output logic signed [RES_WIDTH-1:0]   resid
);
    localparam int MW = LINE_WIDTH + COORD_WIDTH;

    logic signed [MW-1:0]        m0_reg;
    logic signed [MW-1:0]        m1_reg;
    logic signed [MW-1:0]        c0s_reg;
    logic signed [RES_WIDTH-1:0] resid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[epic_pkg::ST_MUL])
        begin
            m0_reg  <= a0 * x0;
            m1_reg  <= b0 * y0;
            c0s_reg <= MW'(c0) <<< COORD_FRAC;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[epic_pkg::ST_RES])
        begin
            resid_reg <= RES_WIDTH'(m0_reg) + RES_WIDTH'(m1_reg) + RES_WIDTH'(c0s_reg);
        end
    end

    assign resid = resid_reg;
endmodule

[hw/rtl/epic_test_unit.sv]
module epic_test_unit #(
    parameter int COORD_FRAC = 4,
    parameter int SQ_WIDTH   = 76,
    parameter int RSQ_WIDTH  = 112
) (
    input  logic                                clk,
    input  epic_pkg::stage_ctrl_t               ctrl,
    input  logic [epic_pkg::THRESH_WIDTH-1:0]   threshold,
    input  logic [SQ_WIDTH-1:0]                 a0_sq,
    input  logic [SQ_WIDTH-1:0]                 b0_sq,
    input  logic [SQ_WIDTH-1:0]                 a1_sq,
    input  logic [SQ_WIDTH-1:0]                 b1_sq,
    input  logic [RSQ_WIDTH-1:0]                rsq,
    output logic                                is_inlier
);
    localparam int TW    = epic_pkg::TSQ_WIDTH;
    localparam int NW    = SQ_WIDTH + 1;
    localparam int NH    = (NW + 1) / 2;
    localparam int NHW   = NW - NH;
    localparam int RHW   = NW + TW;
    localparam int SHIFT = epic_pkg::TSQ_FRAC - 2 * COORD_FRAC;
    localparam int LHW   = RSQ_WIDTH + SHIFT;
    localparam int CMPW  = (LHW > RHW) ? LHW : RHW;

    logic [TW-1:0]     tsq_reg;
    logic [NW-1:0]     n0_reg;
    logic [NW-1:0]     n1_reg;
    logic [NH+TW-1:0]  q0lo_reg;
    logic [NHW+TW-1:0] q0hi_reg;
    logic [NH+TW-1:0]  q1lo_reg;
    logic [NHW+TW-1:0] q1hi_reg;
    logic [RHW-1:0]    rhs0_reg;
    logic [RHW-1:0]    rhs1_reg;
    logic [LHW-1:0]    lhs_reg;
    logic              inlier_reg;

    // The user must change the threshold only while the pipeline is empty; the block itself does not enforce it.
    always_ff @(posedge clk)
    begin
        tsq_reg <= threshold * threshold;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[epic_pkg::ST_NORM])
        begin
            n0_reg <= NW'(a0_sq) + NW'(b0_sq);
            n1_reg <= NW'(a1_sq) + NW'(b1_sq);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[epic_pkg::ST_RSQ])
        begin
            q0lo_reg <= tsq_reg * n0_reg[NH-1:0];
            q0hi_reg <= tsq_reg * n0_reg[NW-1:NH];
            q1lo_reg <= tsq_reg * n1_reg[NH-1:0];
            q1hi_reg <= tsq_reg * n1_reg[NW-1:NH];
        end
    end

    // Both sides are brought to the fraction of the threshold product.
    always_ff @(posedge clk)
    begin
        if (ctrl.load[epic_pkg::ST_RHS])
        begin
            rhs0_reg <= RHW'(q0lo_reg) + (RHW'(q0hi_reg) << NH);
            rhs1_reg <= RHW'(q1lo_reg) + (RHW'(q1hi_reg) << NH);
            lhs_reg  <= LHW'(rsq) << SHIFT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[epic_pkg::ST_CMP])
        begin
            inlier_reg <= (CMPW'(lhs_reg) < CMPW'(rhs0_reg))
                       && (CMPW'(lhs_reg) < CMPW'(rhs1_reg));
        end
    end

    assign is_inlier = inlier_reg;
endmodule

[hw/rtl/epipolar_inlier_check.sv]
// Channel   Modport  Payload                                 Request
// pair      sink     first_x, first_y, second_x, second_y    one point correspondence
// result    source   is_inlier                               one verdict per pair
// cfg_*     write    cfg_index, cfg_data                     one register write
//
// One pair is taken every cycle unless a stalled result side has filled the
// pipeline; each verdict is offered once its request has passed the eight
// register stages of the arithmetic pipeline.
// Reset clears every stage valid bit and loads F with zeros and the threshold
// with 1.0 pixel. A stage holds while its successor is full and cannot move on,
// so empty stages close up and a new request is still taken while a verdict
// waits as long as some stage is empty.
module epipolar_inlier_check #(
    parameter int COORD_WIDTH = 16,
    parameter int COORD_FRAC  = 4,
    parameter int COEF_WIDTH  = 21
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    epic_pair_if.sink                              pair,
    epic_result_if.source                          result,
    input  logic                                   cfg_we,
    input  logic [epic_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [epic_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
    localparam int LW = COORD_WIDTH + COEF_WIDTH + 1;
    localparam int RW = LW + COORD_WIDTH + 2;

    logic [epic_pkg::CFG_DATA_WIDTH-1:0] f_row_reg [epic_pkg::NUM_F_ROWS];
    logic [epic_pkg::THRESH_WIDTH-1:0]   thresh_reg;

    epic_pkg::stage_ctrl_t         ctrl;
    logic signed [LW-1:0]          a0;
    logic signed [LW-1:0]          b0;
    logic signed [LW-1:0]          c0;
    logic signed [LW-1:0]          a1;
    logic signed [LW-1:0]          b1;
    logic signed [COORD_WIDTH-1:0] x0;
    logic signed [COORD_WIDTH-1:0] y0;
    logic signed [RW-1:0]          resid;
    logic [2*LW-1:0]               a0_sq;
    logic [2*LW-1:0]               b0_sq;
    logic [2*LW-1:0]               a1_sq;
    logic [2*LW-1:0]               b1_sq;
    logic [2*RW-1:0]               rsq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < epic_pkg::NUM_F_ROWS; i++)
            begin
                f_row_reg[i] <= '0;
            end
            thresh_reg <= epic_pkg::THRESH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (epic_pkg::cfg_index_t'(cfg_index))
                epic_pkg::CFG_F_ROW0:         f_row_reg[0] <= cfg_data;
                epic_pkg::CFG_F_ROW1:         f_row_reg[1] <= cfg_data;
                epic_pkg::CFG_F_ROW2:         f_row_reg[2] <= cfg_data;
                epic_pkg::CFG_DIST_THRESHOLD:
                    thresh_reg <= cfg_data[epic_pkg::THRESH_WIDTH-1:0];
                default:                      thresh_reg <= thresh_reg;
            endcase
        end
    end

    epic_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pair.valid),
        .in_ready  (pair.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .ctrl      (ctrl)
    );

    epic_line_unit #(
        .COORD_WIDTH (COORD_WIDTH),
        .COORD_FRAC  (COORD_FRAC),
        .COEF_WIDTH  (COEF_WIDTH),
        .LINE_WIDTH  (LW)
    ) u_line (
        .clk      (clk),
        .ctrl     (ctrl),
        .f_row    (f_row_reg),
        .first_x  (pair.first_x),
        .first_y  (pair.first_y),
        .second_x (pair.second_x),
        .second_y (pair.second_y),
        .a0       (a0),
        .b0       (b0),
        .c0       (c0),
        .a1       (a1),
        .b1       (b1),
        .x0       (x0),
        .y0       (y0)
    );

    epic_resid_unit #(
        .COORD_WIDTH (COORD_WIDTH),
        .COORD_FRAC  (COORD_FRAC),
        .LINE_WIDTH  (LW),
        .RES_WIDTH   (RW)
    ) u_resid (
        .clk   (clk),
        .ctrl  (ctrl),
        .a0    (a0),
        .b0    (b0),
        .c0    (c0),
        .x0    (x0),
        .y0    (y0),
        .resid (resid)
    );

    epic_square #(.WIDTH(LW)) u_sq_a0 (
        .clk     (clk),
        .en_part (ctrl.load[epic_pkg::ST_MUL]),
        .en_sum  (ctrl.load[epic_pkg::ST_RES]),
        .value   (a0),
        .square  (a0_sq)
    );

    epic_square #(.WIDTH(LW)) u_sq_b0 (
        .clk     (clk),
        .en_part (ctrl.load[epic_pkg::ST_MUL]),
        .en_sum  (ctrl.load[epic_pkg::ST_RES]),
        .value   (b0),
        .square  (b0_sq)
    );

    epic_square #(.WIDTH(LW)) u_sq_a1 (
        .clk     (clk),
        .en_part (ctrl.load[epic_pkg::ST_MUL]),
        .en_sum  (ctrl.load[epic_pkg::ST_RES]),
        .value   (a1),
        .square  (a1_sq)
    );

    epic_square #(.WIDTH(LW)) u_sq_b1 (
        .clk     (clk),
        .en_part (ctrl.load[epic_pkg::ST_MUL]),
        .en_sum  (ctrl.load[epic_pkg::ST_RES]),
        .value   (b1),
        .square  (b1_sq)
    );

    epic_square #(.WIDTH(RW)) u_sq_r (
        .clk     (clk),
        .en_part (ctrl.load[epic_pkg::ST_NORM]),
        .en_sum  (ctrl.load[epic_pkg::ST_RSQ]),
        .value   (resid),
        .square  (rsq)
    );

    epic_test_unit #(
        .COORD_FRAC (COORD_FRAC),
        .SQ_WIDTH   (2 * LW),
        .RSQ_WIDTH  (2 * RW)
    ) u_test (
        .clk       (clk),
        .ctrl      (ctrl),
        .threshold (thresh_reg),
        .a0_sq     (a0_sq),
        .b0_sq     (b0_sq),
        .a1_sq     (a1_sq),
        .b1_sq     (b1_sq),
        .rsq       (rsq),
        .is_inlier (result.is_inlier)
    );
endmodule

[bench/epic_verdict_checker.sv]
module epic_verdict_checker
    import epic_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int COORD_FRAC  = 4,
    parameter int COEF_WIDTH  = 21
) (
    input  logic                       clk,
    input  logic                       rst_n,
    epic_pair_if                       pair,
    epic_result_if                     result,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                         fail_count,
    output int                         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Wide enough that none of the squared terms can wrap.
    typedef logic signed [255:0] exact_t;

    typedef struct {
        int unsigned seq;
        logic        verdict;
    } verdict_t;

    localparam longint SCALE = longint'(1) << COORD_FRAC;

    logic [CFG_DATA_WIDTH-1:0] f_rows [NUM_F_ROWS];
    logic [THRESH_WIDTH-1:0]   thresh;
    verdict_t                  expected_verdicts [$];
    int unsigned               pairs_seen;
    int                        errors;

    function automatic logic predict_inlier(
        input logic signed [COORD_WIDTH-1:0] x0,
        input logic signed [COORD_WIDTH-1:0] y0,
        input logic signed [COORD_WIDTH-1:0] x1,
        input logic signed [COORD_WIDTH-1:0] y1
    );
        longint f [3][3];
        exact_t a0, b0, c0, a1, b1, r, lhs, t, tsq;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                f[i][j] = $signed(f_rows[i][j*COEF_WIDTH +: COEF_WIDTH]);
        // Line in the first image from the second point, and the first two
        // terms of the line in the second image from the first point.
        a0 = x1 * f[0][0] + y1 * f[1][0] + f[2][0] * SCALE;
        b0 = x1 * f[0][1] + y1 * f[1][1] + f[2][1] * SCALE;
        c0 = x1 * f[0][2] + y1 * f[1][2] + f[2][2] * SCALE;
        a1 = x0 * f[0][0] + y0 * f[0][1] + f[0][2] * SCALE;
        b1 = x0 * f[1][0] + y0 * f[1][1] + f[1][2] * SCALE;
        r = a0 * x0 + b0 * y0 + c0 * SCALE;
        // Residual carries twice the coordinate fraction, the squared
        // threshold sixteen bits; both sides are brought to one scale.
        lhs = (r * r) <<< TSQ_FRAC;
        t = thresh;
        tsq = (t * t) <<< (2 * COORD_FRAC);
        return (lhs < tsq * (a0 * a0 + b0 * b0)) && (lhs < tsq * (a1 * a1 + b1 * b1));
    endfunction

    always @(posedge clk or negedge rst_n) begin
        verdict_t head;
        logic     got;
        if (!rst_n) begin
            f_rows = '{default: '0};
            thresh = THRESH_RESET;
            expected_verdicts.delete();
            pairs_seen = 0;
            errors = 0;
            fail_count <= 0;
            outstanding <= 0;
        end
        else begin
            if (pair.valid && pair.ready) begin
                expected_verdicts.push_back(verdict_t'{pairs_seen,
                    predict_inlier(pair.first_x, pair.first_y,
                                   pair.second_x, pair.second_y)});
                pairs_seen++;
            end
            if (result.valid && result.ready) begin
                got = result.is_inlier;
                if (expected_verdicts.size() == 0) begin
                    if (errors < 10)
                        $display("verdict %0b arrived with no request pending", got);
                    errors++;
                end
                else begin
                    head = expected_verdicts.pop_front();
                    if (got !== head.verdict) begin
                        if (errors < 10)
                            $display("pair %0d: is_inlier expected %0b, got %0b",
                                     head.seq, head.verdict, got);
                        errors++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_F_ROW0:         f_rows[0] = cfg_data;
                    CFG_F_ROW1:         f_rows[1] = cfg_data;
                    CFG_F_ROW2:         f_rows[2] = cfg_data;
                    CFG_DIST_THRESHOLD: thresh = cfg_data[THRESH_WIDTH-1:0];
                    default:            ;
                endcase
            end
            fail_count <= errors;
            outstanding <= expected_verdicts.size();
        end
    end

endmodule

[bench/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import epic_pkg::*;

    localparam int     COORD_WIDTH       = 16;
    localparam int     COORD_FRAC        = 4;
    localparam int     COEF_WIDTH        = 21;
    localparam longint SCALE             = longint'(1) << COORD_FRAC;
    localparam longint COORD_MAX         = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN         = -(longint'(1) << (COORD_WIDTH - 1));
    localparam longint COEF_MAX          = (longint'(1) << (COEF_WIDTH - 1)) - 1;
    localparam longint COEF_MIN          = -(longint'(1) << (COEF_WIDTH - 1));
    localparam int     NUM_PHASES        = 8;
    localparam int     PAIRS_PER_PHASE   = 205;
    localparam int     LONG_STALL_CYCLES = 300;
    localparam int     CYCLE_LIMIT       = 200000;

    typedef enum {F_TRANSLATION, F_SMALL, F_FULL, F_EXTREME} f_style_t;
    typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_MOSTLY} rx_mode_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;
    int                         fail_count;
    int                         outstanding;
    int                         long_stall_req = 0;
    int                         long_stall_done = 0;

    // Current F and threshold, kept so that pairs can be placed near lines.
    longint                     f_coef [3][3];
    logic [THRESH_WIDTH-1:0]    thresh_q88;

    epic_pair_if #(.COORD_WIDTH(COORD_WIDTH)) pair_ch ();
    epic_result_if result_ch ();

    epipolar_inlier_check #(
        .COORD_WIDTH (COORD_WIDTH),
        .COORD_FRAC  (COORD_FRAC),
        .COEF_WIDTH  (COEF_WIDTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair      (pair_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    epic_verdict_checker #(
        .COORD_WIDTH (COORD_WIDTH),
        .COORD_FRAC  (COORD_FRAC),
        .COEF_WIDTH  (COEF_WIDTH)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pair        (pair_ch),
        .result      (result_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_coord(longint v);
        return (v > COORD_MAX) ? COORD_MAX : ((v < COORD_MIN) ? COORD_MIN : v);
    endfunction

    // Uniform in [-span, span].
    function automatic longint spread(longint span);
        longint v;
        v = $urandom_range(0, 2 * span);
        return v - span;
    endfunction

    function automatic longint rand_coef();
        longint v;
        v = $urandom_range(0, 2 * COEF_MAX + 1);
        return v + COEF_MIN;
    endfunction

    function automatic longint extreme_coord();
        case ($urandom_range(0, 5))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            default: return spread(COORD_MAX);
        endcase
    endfunction

    function automatic longint extreme_coef();
        case ($urandom_range(0, 4))
            0:       return COEF_MIN;
            1:       return COEF_MAX;
            2:       return 0;
            3:       return 1;
            default: return -1;
        endcase
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] packed_row(int row);
        logic [CFG_DATA_WIDTH-1:0] v;
        v = '0;
        for (int col = 0; col < 3; col++)
            v[col*COEF_WIDTH +: COEF_WIDTH] = COEF_WIDTH'(f_coef[row][col]);
        return v;
    endfunction

    // Writes all four registers back to back; the block must be idle.
    task automatic load_setting();
        cfg_we <= 1'b1;
        cfg_index <= CFG_F_ROW0;
        cfg_data <= packed_row(0);
        @(posedge clk);
        cfg_index <= CFG_F_ROW1;
        cfg_data <= packed_row(1);
        @(posedge clk);
        cfg_index <= CFG_F_ROW2;
        cfg_data <= packed_row(2);
        @(posedge clk);
        cfg_index <= CFG_DIST_THRESHOLD;
        cfg_data <= CFG_DATA_WIDTH'(thresh_q88);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic offer_pair(longint x0, longint y0, longint x1, longint y1);
        pair_ch.valid <= 1'b1;
        pair_ch.first_x <= COORD_WIDTH'(clamp_coord(x0));
        pair_ch.first_y <= COORD_WIDTH'(clamp_coord(y0));
        pair_ch.second_x <= COORD_WIDTH'(clamp_coord(x1));
        pair_ch.second_y <= COORD_WIDTH'(clamp_coord(y1));
        do @(posedge clk); while (!pair_ch.ready);
    endtask

    task automatic pause_sender(int cycles);
        pair_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        pair_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Picks a first point, solves the epipolar line in the second image for
    // the coordinate with the larger coefficient, then nudges it by noise.
    task automatic near_line_pair(longint span, longint noise);
        longint x0, y0, x1, y1, a1, b1, c1, mag_a, mag_b;
        x0 = spread(span);
        y0 = spread(span);
        x1 = spread(span);
        y1 = spread(span);
        a1 = x0 * f_coef[0][0] + y0 * f_coef[0][1] + f_coef[0][2] * SCALE;
        b1 = x0 * f_coef[1][0] + y0 * f_coef[1][1] + f_coef[1][2] * SCALE;
        c1 = (x0 * f_coef[2][0] + y0 * f_coef[2][1] + f_coef[2][2] * SCALE) * SCALE;
        mag_a = (a1 < 0) ? -a1 : a1;
        mag_b = (b1 < 0) ? -b1 : b1;
        if (mag_b != 0 && mag_b >= mag_a)
            y1 = -(x1 * a1 + c1) / b1 + spread(noise);
        else if (mag_a != 0)
            x1 = -(y1 * b1 + c1) / a1 + spread(noise);
        offer_pair(x0, y0, x1, y1);
    endtask

    task automatic random_pair();
        int     kind;
        longint span, noise;
        kind = $urandom_range(0, 19);
        span = ($urandom_range(0, 7) == 0) ? COORD_MAX : 8192;
        noise = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 24);
        if (kind < 14)
            near_line_pair(span, noise);
        else if (kind < 17)
            offer_pair(spread(COORD_MAX), spread(COORD_MAX),
                       spread(COORD_MAX), spread(COORD_MAX));
        else
            offer_pair(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
    endtask

    task automatic choose_f(f_style_t style);
        longint tx, ty, tz, gain;
        case (style)
            F_TRANSLATION:
            begin
                tx = spread(64);
                ty = spread(64);
                tz = spread(64);
                gain = $urandom_range(1, 16000);
                f_coef = '{'{0, -tz * gain, ty * gain},
                           '{tz * gain, 0, -tx * gain},
                           '{-ty * gain, tx * gain, 0}};
            end
            F_SMALL:
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        f_coef[i][j] = spread(1024);
            F_FULL:
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        f_coef[i][j] = rand_coef();
            default:
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        f_coef[i][j] = extreme_coef();
        endcase
    endtask

    task automatic run_phase(int pairs, bit with_long_stall, bit with_pause);
        int sent;
        int burst;
        bit stalled;
        bit paused;
        sent = 0;
        stalled = 0;
        paused = 0;
        while (sent < pairs) begin
            // Keep offering while the result side holds off, so the pipeline
            // fills and the pair channel has to stall.
            if (with_long_stall && !stalled && sent >= 60) begin
                stalled = 1;
                long_stall_req++;
                for (int k = 0; k < 40; k++)
                    random_pair();
                sent += 40;
            end
            if (with_pause && !paused && sent >= pairs / 2) begin
                paused = 1;
                drain();
            end
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < pairs; k++) begin
                random_pair();
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 10));
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_F_ROW0;
        cfg_data <= '0;
        pair_ch.valid <= 1'b0;
        pair_ch.first_x <= '0;
        pair_ch.first_y <= '0;
        pair_ch.second_x <= '0;
        pair_ch.second_y <= '0;
        f_coef = '{default: 0};
        thresh_q88 = THRESH_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset F is all zeros, so every line is degenerate.
        offer_pair(0, 0, 0, 0);
        offer_pair(COORD_MAX, COORD_MIN, 100, -100);
        offer_pair(-320, 160, 320, -160);
        drain();

        // Pure translation with both epipoles at (3, -2) px.
        f_coef = '{'{0, -1, -2}, '{1, 0, -3}, '{2, 3, 0}};
        thresh_q88 = THRESH_RESET;
        load_setting();
        offer_pair(48, -32, 100, 200);
        offer_pair(100, 200, 48, -32);
        offer_pair(48, -32, 48, -32);
        offer_pair(0, 0, -48, 32);
        offer_pair(0, 0, -48, 48);
        offer_pair(0, 0, -48, 36);
        offer_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        offer_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        offer_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        offer_pair(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        offer_pair(-1, -1, 1, 1);
        drain();

        // A zero threshold rejects even a pair exactly on its line.
        thresh_q88 = '0;
        load_setting();
        offer_pair(0, 0, -48, 32);
        offer_pair(160, 80, -96, 64);
        drain();

        f_coef = '{'{COEF_MAX, COEF_MIN, COEF_MAX},
                   '{COEF_MIN, COEF_MAX, COEF_MIN},
                   '{COEF_MAX, COEF_MAX, COEF_MIN}};
        thresh_q88 = 16'hFFFF;
        load_setting();
        offer_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        offer_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        offer_pair(0, 0, 0, 0);
        drain();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:
                begin
                    choose_f(F_TRANSLATION);
                    thresh_q88 = $urandom_range(16, 2048);
                end
                1:
                begin
                    choose_f(F_SMALL);
                    thresh_q88 = THRESH_RESET;
                end
                2:
                begin
                    choose_f(F_FULL);
                    thresh_q88 = $urandom_range(0, 65535);
                end
                3:
                begin
                    choose_f(F_EXTREME);
                    thresh_q88 = 16'hFFFF;
                end
                4:
                begin
                    choose_f(F_TRANSLATION);
                    thresh_q88 = '0;
                end
                5:
                begin
                    choose_f(F_TRANSLATION);
                    thresh_q88 = $urandom_range(16, 2048);
                end
                6:
                begin
                    choose_f(F_SMALL);
                    thresh_q88 = $urandom_range(64, 4096);
                end
                default:
                begin
                    choose_f(F_EXTREME);
                    thresh_q88 = $urandom_range(1, 65535);
                end
            endcase
            load_setting();
            run_phase(PAIRS_PER_PHASE, phase == 2 || phase == 5, phase == 4);
            drain();
        end

        repeat (4 * NUM_STAGES) @(posedge clk);
        if (fail_count == 0)
            $display("epipolar_inlier_check: match");
        else
            $display("epipolar_inlier_check: mismatch");
        $finish;
    end

    // Result side: changing stall patterns, plus long hold-offs on demand.
    initial
    begin
        rx_mode_t mode;
        int       left;
        int       hold;
        mode = RX_OPEN;
        left = 0;
        hold = 0;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold > 0) begin
                result_ch.ready <= 1'b0;
                hold--;
                if (hold == 0)
                    long_stall_done++;
            end
            else if (long_stall_req != long_stall_done) begin
                result_ch.ready <= 1'b0;
                hold = LONG_STALL_CYCLES;
            end
            else begin
                if (left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(16, 160);
                end
                left--;
                case (mode)
                    RX_OPEN:     result_ch.ready <= 1'b1;
                    RX_COIN:     result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: result_ch.ready <= (left % 4 == 0);
                    default:     result_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
            @(posedge clk);
        end
    end

    initial
    begin
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("epipolar_inlier_check: mismatch");
        $finish;
    end

endmodule
